[sv/adex_pkg.sv]
// Shared types, constants and arithmetic helpers of the AdEx neuron update block.
package adex_pkg;

  // Configuration register indexes.
  localparam logic [7:0] REG_MEMBRANE_RATE   = 8'd0;
  localparam logic [7:0] REG_LEAK_COND       = 8'd1;
  localparam logic [7:0] REG_REST_POTENTIAL  = 8'd2;
  localparam logic [7:0] REG_THRESHOLD       = 8'd3;
  localparam logic [7:0] REG_SLOPE_FACTOR    = 8'd4;
  localparam logic [7:0] REG_ADAPT_COUPLING  = 8'd5;
  localparam logic [7:0] REG_ADAPT_INCREMENT = 8'd6;
  localparam logic [7:0] REG_SPIKE_POTENTIAL = 8'd7;

  // Register values after reset.
  localparam logic [30:0] RST_MEMBRANE_RATE   = 31'd23;
  localparam logic [30:0] RST_LEAK_COND       = 31'd1966080;
  localparam logic signed [31:0] RST_REST     = -32'sd4626842;
  localparam logic signed [31:0] RST_THRESH   = -32'sd3303014;
  localparam logic [30:0] RST_SLOPE_FACTOR    = 31'd131072;
  localparam logic signed [31:0] RST_COUPLING = 32'sd262144;
  localparam logic signed [31:0] RST_INCREMENT = 32'sd5276;
  localparam logic signed [31:0] RST_SPIKE    = 32'sd1310720;

  // log2(e) and the exp2 polynomial coefficients, Q16.16.
  localparam logic signed [31:0] LOG2E_Q16 = 32'sd94548;
  localparam logic signed [31:0] POLY_C3   = 32'sd5137;
  localparam logic [17:0] POLY_C2 = 18'd14812;
  localparam logic [17:0] POLY_C1 = 18'd45587;
  localparam logic [17:0] POLY_C0 = 18'd65536;

  localparam logic signed [31:0] S32_MAX = 32'sh7FFFFFFF;
  localparam logic signed [31:0] S32_MIN = 32'sh80000000;

  // Datapath micro-operations issued by the controller.
  typedef enum logic [4:0] {
    ST_NONE, ST_LOAD, ST_INIT, ST_GD, ST_D0, ST_LM, ST_LIN, ST_UDIV, ST_MT, ST_T,
    ST_M1, ST_P1, ST_M2, ST_P2, ST_M3, ST_P3, ST_E, ST_MEX, ST_FX, ST_SUM,
    ST_MX, ST_X, ST_XD, ST_MA, ST_DW, ST_WST, ST_WDIV, ST_CHK, ST_WB
  } step_t;

  typedef struct packed {
    logic  accept;
    step_t step;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic op_reset;
    logic idx_ok;
    logic spike;
  } status_t;

  // Saturate a 34-bit sum to signed 32 bits.
  function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
    if (v > 34'(S32_MAX)) return S32_MAX;
    if (v < 34'(S32_MIN)) return S32_MIN;
    return v[31:0];
  endfunction

  // Q16.16 product: shift right by 16 rounding toward minus infinity, then saturate.
  function automatic logic signed [31:0] prod(input logic signed [63:0] m);
    logic signed [47:0] s;
    s = m[63:16];
    if (s > 48'(S32_MAX)) return S32_MAX;
    if (s < 48'(S32_MIN)) return S32_MIN;
    return s[31:0];
  endfunction

endpackage

[sv/adex_ifs.sv]
// Channel interfaces: item input, result output and configuration write.
interface adex_in_if;
  logic               valid;
  logic               ready;
  logic               op;
  logic [9:0]         neuron;
  logic signed [31:0] input_current;
  modport source (output valid, op, neuron, input_current, input ready);
  modport sink (input valid, op, neuron, input_current, output ready);
endinterface

interface adex_out_if;
  logic               valid;
  logic               ready;
  logic [9:0]         neuron_out;
  logic               fired;
  logic signed [31:0] potential;
  modport source (output valid, neuron_out, fired, potential, input ready);
  modport sink (input valid, neuron_out, fired, potential, output ready);
endinterface

interface adex_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[sv/adex_neuron_update_top.sv]
// Top level of the adaptive exponential integrate-and-fire neuron update block.
// A reset item or out-of-range index passes only the load, init and write-back states.
// An update runs k substeps (k up to SUBSTEPS, fewer once the neuron spikes); each
// substep includes the bit-serial slope division.
// One item is in work at a time; the next can be accepted in the same cycle as a result shows.
// Reset (rst, synchronous) clears control and restores register defaults; the
// neuron memories hold no defined value until an entry is written.
module adex_neuron_update_top
  import adex_pkg::*;
#(
  parameter int NEURONS   = 1024,
  parameter int SUBSTEPS  = 10,
  parameter int ADAPT_TAU = 144
) (
  input logic       clk,
  input logic       rst,
  adex_cfg_if.sink  cfg,
  adex_in_if.sink   req,
  adex_out_if.source rsp
);
  cmd_t    cmd;
  status_t status;

  assign cfg.ready = 1'b1;

  adex_ctrl #(.SUBSTEPS(SUBSTEPS)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .status    (status),
    .cmd       (cmd)
  );

  adex_datapath #(
    .NEURONS   (NEURONS),
    .SUBSTEPS  (SUBSTEPS),
    .ADAPT_TAU (ADAPT_TAU)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg.valid && cfg.ready),
    .cfg_index     (cfg.index),
    .cfg_data      (cfg.data),
    .cmd           (cmd),
    .in_op         (req.op),
    .in_neuron     (req.neuron),
    .in_current    (req.input_current),
    .status        (status),
    .neuron_out    (rsp.neuron_out),
    .fired_out     (rsp.fired),
    .potential_out (rsp.potential)
  );
endmodule

[sv/adex_div.sv]
// Radix-2 restoring divider, signed dividend, positive divisor, saturated quotient.
module adex_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [48:0] dividend,
  input  logic [30:0]        divisor,
  output logic               done,
  output logic signed [31:0] quot
);
  localparam int QW = 48;
  localparam logic [31:0] S32_MAX_U = 32'h7FFFFFFF;

  logic          busy;
  logic [5:0]    cnt;
  logic [30:0]   rem;
  logic [QW-1:0] q;
  logic          neg;
  logic [30:0]   dvs;
  logic [31:0]   trial;
  logic          ge;
  logic signed [48:0] mag;

  assign mag   = dividend[48] ? -dividend : dividend;
  assign trial = {rem, q[QW-1]};
  assign ge    = trial >= {1'b0, dvs};

  // One quotient bit per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'(QW);
        rem  <= '0;
        q    <= mag[QW-1:0];
        neg  <= dividend[48];
        dvs  <= divisor;
      end else if (busy) begin
        rem <= ge ? 31'(trial - {1'b0, dvs}) : trial[30:0];
        q   <= {q[QW-2:0], ge};
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Apply the sign and saturate; the magnitude was truncated toward zero.
  always_comb begin
    if (!neg) begin
      quot = (q > QW'(S32_MAX_U)) ? 32'sh7FFFFFFF : q[31:0];
    end else begin
      quot = (q > QW'(S32_MAX_U) + QW'(1)) ? 32'sh80000000 : -$signed(q[31:0]);
    end
  end
endmodule

[sv/adex_ctrl.sv]
// Controller: sequences one item through the substeps of the shared datapath.
module adex_ctrl
  import adex_pkg::*;
#(
  parameter int SUBSTEPS = 10
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  status_t status,
  output cmd_t    cmd
);
  localparam int KW = (SUBSTEPS > 1) ? $clog2(SUBSTEPS) : 1;

  typedef enum logic [4:0] {
    S_IDLE, S_LOAD, S_INIT, S_GD, S_D0, S_LM, S_LIN, S_UDIV, S_MT, S_T,
    S_M1, S_P1, S_M2, S_P2, S_M3, S_P3, S_E, S_MEX, S_FX, S_SUM,
    S_MX, S_X, S_XD, S_MA, S_DW, S_WST, S_WDIV, S_CHK, S_WB
  } state_t;

  state_t      state;
  logic [KW-1:0] k;
  logic        out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  // Command decode.
  always_comb begin
    cmd.accept = in_valid && in_ready;
    unique case (state)
      S_IDLE: cmd.step = ST_NONE;
      S_LOAD: cmd.step = ST_LOAD;
      S_INIT: cmd.step = ST_INIT;
      S_GD:   cmd.step = ST_GD;
      S_D0:   cmd.step = ST_D0;
      S_LM:   cmd.step = ST_LM;
      S_LIN:  cmd.step = ST_LIN;
      S_UDIV: cmd.step = ST_UDIV;
      S_MT:   cmd.step = ST_MT;
      S_T:    cmd.step = ST_T;
      S_M1:   cmd.step = ST_M1;
      S_P1:   cmd.step = ST_P1;
      S_M2:   cmd.step = ST_M2;
      S_P2:   cmd.step = ST_P2;
      S_M3:   cmd.step = ST_M3;
      S_P3:   cmd.step = ST_P3;
      S_E:    cmd.step = ST_E;
      S_MEX:  cmd.step = ST_MEX;
      S_FX:   cmd.step = ST_FX;
      S_SUM:  cmd.step = ST_SUM;
      S_MX:   cmd.step = ST_MX;
      S_X:    cmd.step = ST_X;
      S_XD:   cmd.step = ST_XD;
      S_MA:   cmd.step = ST_MA;
      S_DW:   cmd.step = ST_DW;
      S_WST:  cmd.step = ST_WST;
      S_WDIV: cmd.step = ST_WDIV;
      S_CHK:  cmd.step = ST_CHK;
      S_WB:   cmd.step = out_free ? ST_WB : ST_NONE;
      default: cmd.step = ST_NONE;
    endcase
  end

  // State, substep counter and result valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      k         <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == S_WB && out_free) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (in_valid) state <= S_LOAD;
        S_LOAD: state <= S_INIT;
        S_INIT: begin
          k <= '0;
          state <= (status.op_reset || !status.idx_ok) ? S_WB : S_GD;
        end
        S_GD:   state <= S_D0;
        S_D0:   state <= S_LM;
        S_LM:   state <= S_LIN;
        S_LIN:  state <= S_UDIV;
        S_UDIV: if (status.div_done) state <= S_MT;
        S_MT:   state <= S_T;
        S_T:    state <= S_M1;
        S_M1:   state <= S_P1;
        S_P1:   state <= S_M2;
        S_M2:   state <= S_P2;
        S_P2:   state <= S_M3;
        S_M3:   state <= S_P3;
        S_P3:   state <= S_E;
        S_E:    state <= S_MEX;
        S_MEX:  state <= S_FX;
        S_FX:   state <= S_SUM;
        S_SUM:  state <= S_MX;
        S_MX:   state <= S_X;
        S_X:    state <= S_XD;
        S_XD:   state <= S_MA;
        S_MA:   state <= S_DW;
        S_DW:   state <= S_WST;
        S_WST:  state <= S_WDIV;
        S_WDIV: if (status.div_done) state <= S_CHK;
        S_CHK: begin
          if (status.spike || k == KW'(SUBSTEPS - 1)) begin
            state <= S_WB;
          end else begin
            k <= k + KW'(1);
            state <= S_D0;
          end
        end
        S_WB: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // An accepted transaction always starts the memory read next.
  a_accept_load: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_LOAD)) else $error("accept did not load");
  // A finished item raises the result valid.
  a_wb_valid: assert property (@(posedge clk) disable iff (rst)
    (state == S_WB && out_free) |=> out_valid) else $error("result not presented");
  // The substep counter stays within the substep count.
  a_k_range: assert property (@(posedge clk) disable iff (rst)
    (k <= KW'(SUBSTEPS - 1))) else $error("substep counter out of range");
endmodule

[sv/adex_datapath.sv]
// Datapath: configuration, neuron state memories, shared multiplier and divider.
module adex_datapath
  import adex_pkg::*;
#(
  parameter int NEURONS   = 1024,
  parameter int SUBSTEPS  = 10,
  parameter int ADAPT_TAU = 144
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [7:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  cmd_t               cmd,
  input  logic               in_op,
  input  logic [9:0]         in_neuron,
  input  logic signed [31:0] in_current,
  output status_t            status,
  output logic [9:0]         neuron_out,
  output logic               fired_out,
  output logic signed [31:0] potential_out
);
  localparam int AW = (NEURONS > 1) ? $clog2(NEURONS) : 1;
  // Adaptation divisor and its reciprocal, scaled so that it fits 32 bits.
  localparam int WD = ADAPT_TAU * SUBSTEPS;
  localparam int WS = 30 + $clog2(WD + 1);
  localparam logic [63:0] W_RECIP64 = (64'd1 << WS) / 64'(WD);
  localparam logic [31:0] W_RECIP = W_RECIP64[31:0];

  // Configuration registers.
  logic [30:0]        membrane_rate, leak_cond, slope_factor;
  logic signed [31:0] rest_pot, thresh_pot, adapt_coupling, adapt_inc, spike_pot;

  always_ff @(posedge clk) begin
    if (rst) begin
      membrane_rate  <= RST_MEMBRANE_RATE;
      leak_cond      <= RST_LEAK_COND;
      rest_pot       <= RST_REST;
      thresh_pot     <= RST_THRESH;
      slope_factor   <= RST_SLOPE_FACTOR;
      adapt_coupling <= RST_COUPLING;
      adapt_inc      <= RST_INCREMENT;
      spike_pot      <= RST_SPIKE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MEMBRANE_RATE:   membrane_rate  <= cfg_data[30:0];
        REG_LEAK_COND:       leak_cond      <= cfg_data[30:0];
        REG_REST_POTENTIAL:  rest_pot       <= cfg_data;
        REG_THRESHOLD:       thresh_pot     <= cfg_data;
        REG_SLOPE_FACTOR:    slope_factor   <= cfg_data[30:0];
        REG_ADAPT_COUPLING:  adapt_coupling <= cfg_data;
        REG_ADAPT_INCREMENT: adapt_inc      <= cfg_data;
        REG_SPIKE_POTENTIAL: spike_pot      <= cfg_data;
        default: ;
      endcase
    end
  end

  // Item registers.
  logic               op_r;
  logic [9:0]         idx;
  logic signed [31:0] cur;
  logic [AW+9:0]      idx_ext;
  logic [AW-1:0]      addr;
  logic               idx_ok;

  assign idx_ext = {{AW{1'b0}}, idx};
  assign addr    = idx_ext[AW-1:0];
  assign idx_ok  = 32'(idx) < 32'(NEURONS);

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r <= in_op;
      idx  <= in_neuron;
      cur  <= in_current;
    end
  end

  // Neuron state memories with registered read.
  logic signed [31:0] mem_x [NEURONS];
  logic signed [31:0] mem_w [NEURONS];
  logic signed [31:0] rd_x, rd_w;

  // Working registers.
  logic signed [31:0] x, w, d, lin, u, t, e, gd, fx, s, dw;
  logic [17:0]        p;
  logic signed [63:0] m;
  logic               fired;

  // Shared divider for the slope division.
  logic               div_start, div_done;
  logic signed [48:0] div_num;
  logic [30:0]        div_den;
  logic signed [31:0] div_q;
  logic [30:0]        d_t;
  logic signed [32:0] x_vt;

  assign d_t       = (slope_factor == '0) ? 31'd1 : slope_factor;
  assign x_vt      = 33'(x) - 33'(thresh_pot);
  assign div_start = (cmd.step == ST_D0);
  assign div_num   = {x_vt, 16'b0};
  assign div_den   = d_t;

  adex_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (div_den),
    .done     (div_done),
    .quot     (div_q)
  );

  // Adaptation division by a constant: reciprocal multiply, then one correction.
  logic [2:0]         wd_ph;
  logic               wd_done;
  logic               wd_neg;
  logic [31:0]        wd_a, wd_q0, wd_qd, wd_r, wd_mag;
  logic signed [31:0] wd_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      wd_ph <= '0;
    end else begin
      wd_ph <= {wd_ph[1:0], cmd.step == ST_WST};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step == ST_WST) begin
      wd_neg <= dw[31];
      wd_a   <= dw[31] ? 32'(-33'(dw)) : 32'(dw);
    end
    wd_q0 <= 32'((64'(wd_a) * 64'(W_RECIP)) >> WS);
    wd_qd <= 32'(64'(wd_q0) * 64'(WD));
  end

  assign wd_done = wd_ph[2];
  assign wd_r    = wd_a - wd_qd;
  assign wd_mag  = (wd_r >= 32'(WD)) ? wd_q0 + 32'd1 : wd_q0;
  assign wd_q    = wd_neg ? -$signed(wd_mag) : $signed(wd_mag);

  // Multiplier operand select.
  logic signed [31:0] ma, mb, pm, r_s, p_s, e_c;
  logic signed [15:0] n;

  assign pm  = prod(m);
  assign r_s = {16'b0, t[15:0]};
  assign p_s = {14'b0, p};
  assign n   = t[31:16];

  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd.step)
      ST_INIT: begin ma = {1'b0, leak_cond}; mb = {1'b0, d_t}; end
      ST_LM:   begin ma = {1'b0, leak_cond}; mb = d; end
      ST_MT:   begin ma = u; mb = LOG2E_Q16; end
      ST_M1:   begin ma = POLY_C3; mb = r_s; end
      ST_M2, ST_M3: begin ma = p_s; mb = r_s; end
      ST_MEX:  begin ma = gd; mb = e; end
      ST_MX:   begin ma = s; mb = {1'b0, membrane_rate}; end
      ST_MA:   begin ma = adapt_coupling; mb = d; end
      default: ;
    endcase
  end

  // exp2 of t: polynomial mantissa scaled by the integer part.
  always_comb begin
    if (n >= 16'sd15) e_c = S32_MAX;
    else if (n >= 16'sd0) e_c = p_s << n[3:0];
    else if (n < -16'sd31) e_c = '0;
    else e_c = p_s >>> 5'(-n);
  end

  // Micro-operation execution.
  always_ff @(posedge clk) begin
    m <= ma * mb;
    case (cmd.step)
      ST_LOAD: begin
        rd_x <= mem_x[addr];
        rd_w <= mem_w[addr];
      end
      ST_INIT: begin
        fired <= 1'b0;
        x <= op_r ? rest_pot : rd_x;
        w <= op_r ? 32'sd0 : rd_w;
      end
      ST_GD:   gd  <= pm;
      ST_D0:   d   <= sat34(34'(x) - 34'(rest_pot));
      ST_LIN:  lin <= sat34(-34'(pm));
      ST_UDIV: if (div_done) u <= div_q;
      ST_T:    t   <= pm;
      ST_P1:   p   <= POLY_C2 + pm[17:0];
      ST_P2:   p   <= POLY_C1 + pm[17:0];
      ST_P3:   p   <= POLY_C0 + pm[17:0];
      ST_E:    e   <= e_c;
      ST_FX:   fx  <= sat34(34'(lin) + 34'(pm));
      ST_SUM:  s   <= sat34(34'(fx) - 34'(w) + 34'(cur));
      ST_X:    x   <= sat34(34'(x) + 34'(pm));
      ST_XD:   d   <= sat34(34'(x) - 34'(rest_pot));
      ST_DW:   dw  <= sat34(34'(pm) - 34'(w));
      ST_WDIV: if (wd_done) w <= sat34(34'(w) + 34'(wd_q));
      ST_CHK: begin
        if (x >= spike_pot) begin
          x <= rest_pot;
          w <= sat34(34'(w) + 34'(adapt_inc));
          fired <= 1'b1;
        end
      end
      ST_WB: begin
        if (idx_ok) begin
          mem_x[addr] <= x;
          mem_w[addr] <= w;
        end
        neuron_out    <= idx;
        fired_out     <= idx_ok && fired;
        potential_out <= idx_ok ? x : 32'sd0;
      end
      default: ;
    endcase
  end

  assign status.div_done = div_done || wd_done;
  assign status.op_reset = op_r;
  assign status.idx_ok   = idx_ok;
  assign status.spike    = (x >= spike_pot);
endmodule

[dv/adex_neuron_update_top_tb.sv]
// Self-checking testbench of the AdEx neuron update block with a bit-exact predictor.
module adex_neuron_update_top_tb;
  import adex_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NEURONS   = 1024;
  localparam int SUBSTEPS  = 10;
  localparam int ADAPT_TAU = 144;
  localparam int IDLE_LIMIT = 20000;
  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_RESET  = 1'b1;

  typedef struct packed {
    logic               op;
    logic [9:0]         neuron;
    logic signed [31:0] input_current;
  } neuron_cmd_t;

  typedef struct packed {
    logic [9:0]         neuron_out;
    logic               fired;
    logic signed [31:0] potential;
  } neuron_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  adex_cfg_if cfg ();
  adex_in_if  req ();
  adex_out_if rsp ();

  adex_neuron_update_top #(
    .NEURONS(NEURONS), .SUBSTEPS(SUBSTEPS), .ADAPT_TAU(ADAPT_TAU)
  ) DUT (
    .clk(clk), .rst(rst), .cfg(cfg.sink), .req(req.source), .rsp(rsp.sink)
  );

  always #2 clk = ~clk;

  // Predictor state: register copies and both neuron stores.
  longint m_rate, g_leak, v_rest, v_thr, d_slope, a_coup, b_inc, v_spike;
  longint v_mem[NEURONS];
  longint w_mem[NEURONS];
  bit     written[NEURONS];

  neuron_cmd_t cmd_queue[$];
  neuron_res_t expected_results[$];
  int  errors = 0;
  int  cmds_sent = 0;
  int  hold_off = 0;
  logic [7:0]  cfg_index_q;
  logic [31:0] cfg_data_q;
  bit cfg_req = 1'b0;
  bit cfg_ack = 1'b0;

  function automatic longint sat(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Q16.16 product with floor rounding and saturation.
  function automatic longint qmul(longint a, longint b);
    longint p;
    p = a * b;
    return sat(p >>> 16);
  endfunction

  function automatic longint exp_q16(longint u);
    longint t, n, r, p;
    t = qmul(u, 94548);
    n = t >>> 16;
    r = t - n * 65536;
    p = 5137;
    p = 14812 + ((p * r) >>> 16);
    p = 45587 + ((p * r) >>> 16);
    p = 65536 + ((p * r) >>> 16);
    if (n >= 15) return 64'sd2147483647;
    if (n >= 0) return p <<< n;
    if (n < -31) return 0;
    return p >>> (-n);
  endfunction

  // One forward Euler substep on potential x and adaptation w.
  function automatic void euler_substep(inout longint x, inout longint w, input longint cur);
    longint dt, d, lin, u, ex, fx, dw;
    dt = (d_slope == 0) ? 1 : d_slope;
    d = sat(x - v_rest);
    lin = sat(-qmul(g_leak, d));
    u = sat(((x - v_thr) * 65536) / dt);
    ex = qmul(qmul(g_leak, dt), exp_q16(u));
    fx = sat(lin + ex);
    x = sat(x + qmul(sat(fx - w + cur), m_rate));
    dw = sat(qmul(a_coup, sat(x - v_rest)) - w);
    w = sat(w + dw / (ADAPT_TAU * SUBSTEPS));
  endfunction

  function automatic neuron_res_t predict_neuron(neuron_cmd_t c);
    neuron_res_t r;
    longint x, w;
    r.neuron_out = c.neuron;
    r.fired = 1'b0;
    if (c.op == OP_RESET) begin
      x = v_rest;
      w = 0;
    end else begin
      x = v_mem[c.neuron];
      w = w_mem[c.neuron];
      for (int k = 0; k < SUBSTEPS; k++) begin
        euler_substep(x, w, longint'(c.input_current));
        if (x >= v_spike) begin
          x = v_rest;
          w = sat(w + b_inc);
          r.fired = 1'b1;
          break;
        end
      end
    end
    v_mem[c.neuron] = x;
    w_mem[c.neuron] = w;
    r.potential = x[31:0];
    return r;
  endfunction

  function automatic void apply_config(logic [7:0] idx, logic [31:0] val);
    case (idx)
      REG_MEMBRANE_RATE:   m_rate  = longint'(val[30:0]);
      REG_LEAK_COND:       g_leak  = longint'(val[30:0]);
      REG_REST_POTENTIAL:  v_rest  = longint'(signed'(val));
      REG_THRESHOLD:       v_thr   = longint'(signed'(val));
      REG_SLOPE_FACTOR:    d_slope = longint'(val[30:0]);
      REG_ADAPT_COUPLING:  a_coup  = longint'(signed'(val));
      REG_ADAPT_INCREMENT: b_inc   = longint'(signed'(val));
      REG_SPIKE_POTENTIAL: v_spike = longint'(signed'(val));
      default: ;
    endcase
  endfunction

  // Configuration driver: one write per request from the stimulus.
  always @(posedge clk) begin
    if (rst) begin
      cfg.valid <= 1'b0;
      cfg.index <= '0;
      cfg.data <= '0;
    end else if (cfg.valid && cfg.ready) begin
      cfg.valid <= 1'b0;
      cfg_ack <= 1'b1;
    end else if (cfg_req && !cfg_ack && !cfg.valid) begin
      cfg.valid <= 1'b1;
      cfg.index <= cfg_index_q;
      cfg.data <= cfg_data_q;
    end else if (!cfg_req) begin
      cfg_ack <= 1'b0;
    end
  end

  // Item driver: pops pending commands with a random gap before each one.
  int gap_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
      req.op <= 1'b0;
      req.neuron <= '0;
      req.input_current <= '0;
      gap_left <= $urandom_range(0, 9);
    end else if (req.valid && !req.ready) begin
      // Hold the offered transaction.
    end else begin
      if (req.valid) begin
        expected_results.push_back(predict_neuron({req.op, req.neuron, req.input_current}));
        cmds_sent <= cmds_sent + 1;
      end
      if (cmd_queue.size() > 0 && gap_left == 0) begin
        neuron_cmd_t c;
        c = cmd_queue.pop_front();
        req.valid <= 1'b1;
        req.op <= c.op;
        req.neuron <= c.neuron;
        req.input_current <= c.input_current;
        gap_left <= $urandom_range(0, 9);
      end else begin
        req.valid <= 1'b0;
        if (gap_left > 0) gap_left <= gap_left - 1;
      end
    end
  end

  // Monitor: random stalls plus one long hold-off, then compare.
  int stall_left = 0;
  int idle_cycles = 0;
  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
      stall_left <= $urandom_range(0, 9);
    end else begin
      if (rsp.valid && rsp.ready) begin
        neuron_res_t e;
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result neuron %0d", $realtime, rsp.neuron_out);
        end else begin
          e = expected_results.pop_front();
          if (e.neuron_out !== rsp.neuron_out) begin
            errors++;
            $display("%0t: neuron_out exp %0d act %0d", $realtime, e.neuron_out,
                     rsp.neuron_out);
          end
          if (e.fired !== rsp.fired) begin
            errors++;
            $display("%0t: fired exp %0d act %0d", $realtime, e.fired, rsp.fired);
          end
          if (e.potential !== rsp.potential) begin
            errors++;
            $display("%0t: potential exp %0d act %0d", $realtime, e.potential,
                     rsp.potential);
          end
        end
        stall_left <= $urandom_range(0, 9);
        rsp.ready <= 1'b0;
      end else if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        rsp.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= 1'b1;
      end
      // Watchdog on cycles without any accepted transaction.
      if ((rsp.valid && rsp.ready) || (req.valid && req.ready) ||
          (cfg.valid && cfg.ready) || hold_off > 0) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("SCOREBOARD MISMATCH");
          $finish;
        end
      end
    end
  end

  task automatic wait_drained();
    while (cmd_queue.size() > 0 || req.valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [7:0] idx, logic [31:0] val);
    cfg_index_q = idx;
    cfg_data_q = val;
    cfg_req = 1'b1;
    while (!cfg_ack) @(posedge clk);
    apply_config(idx, val);
    cfg_req = 1'b0;
    while (cfg_ack) @(posedge clk);
  endtask

  task automatic push_cmd(logic op, int n, logic signed [31:0] cur);
    logic [9:0] idx;
    idx = n[9:0];
    // An update on a never-written neuron is replaced by a reset.
    if (op == OP_UPDATE && !written[idx]) op = OP_RESET;
    written[idx] = 1'b1;
    cmd_queue.push_back({op, idx, cur});
  endtask

  function automatic logic signed [31:0] rand_current();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return S32_MAX;
      2: return S32_MIN;
      default: return $signed($urandom_range(0, 2000000)) - 32'sd200000;
    endcase
  endfunction

  // Random phase on a small working set of neurons.
  task automatic random_phase(int count);
    int n;
    for (int i = 0; i < count; i++) begin
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 31);
      push_cmd(($urandom_range(0, 9) == 0) ? OP_RESET : OP_UPDATE, n, rand_current());
    end
    wait_drained();
  endtask

  initial begin
    m_rate = RST_MEMBRANE_RATE; g_leak = RST_LEAK_COND; v_rest = RST_REST;
    v_thr = RST_THRESH; d_slope = RST_SLOPE_FACTOR; a_coup = RST_COUPLING;
    b_inc = RST_INCREMENT; v_spike = RST_SPIKE;
    foreach (written[i]) written[i] = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: resets at the index extremes, then updates at current extremes.
    push_cmd(OP_RESET, 0, 0);
    push_cmd(OP_RESET, 1023, S32_MAX);
    push_cmd(OP_RESET, 5, S32_MIN);
    push_cmd(OP_UPDATE, 0, 0);
    push_cmd(OP_UPDATE, 1023, S32_MAX);
    push_cmd(OP_UPDATE, 5, S32_MIN);
    push_cmd(OP_UPDATE, 0, 32'sd3000000);
    push_cmd(OP_UPDATE, 0, 32'sd3000000);
    push_cmd(OP_UPDATE, 1023, -32'sd1);
    push_cmd(OP_RESET, 1023, 0);
    push_cmd(OP_UPDATE, 1023, 32'sd65536);
    wait_drained();

    // Zero slope factor and a fast membrane rate.
    write_reg(REG_SLOPE_FACTOR, 32'd0);
    write_reg(REG_MEMBRANE_RATE, 32'd6553);
    push_cmd(OP_UPDATE, 0, 32'sd100000);
    push_cmd(OP_UPDATE, 5, S32_MAX);
    push_cmd(OP_UPDATE, 1023, S32_MIN);
    wait_drained();

    random_phase(350);

    // Receiver holds off while the sender keeps offering items.
    hold_off = 3000;
    random_phase(300);

    // Register extremes.
    write_reg(REG_MEMBRANE_RATE, 32'h7FFFFFFF);
    write_reg(REG_LEAK_COND, 32'h7FFFFFFF);
    write_reg(REG_REST_POTENTIAL, 32'h80000000);
    write_reg(REG_THRESHOLD, 32'h7FFFFFFF);
    write_reg(REG_SLOPE_FACTOR, 32'h7FFFFFFF);
    write_reg(REG_ADAPT_COUPLING, 32'h80000000);
    write_reg(REG_ADAPT_INCREMENT, 32'h7FFFFFFF);
    write_reg(REG_SPIKE_POTENTIAL, 32'h7FFFFFFF);
    random_phase(150);

    write_reg(REG_MEMBRANE_RATE, 32'd0);
    write_reg(REG_LEAK_COND, 32'd0);
    write_reg(REG_REST_POTENTIAL, 32'h7FFFFFFF);
    write_reg(REG_THRESHOLD, 32'h80000000);
    write_reg(REG_SLOPE_FACTOR, 32'd1);
    write_reg(REG_ADAPT_COUPLING, 32'h7FFFFFFF);
    write_reg(REG_ADAPT_INCREMENT, 32'h80000000);
    write_reg(REG_SPIKE_POTENTIAL, 32'h80000000);
    random_phase(150);

    // Random register settings, some around the nominal values and some over the full range.
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(REG_MEMBRANE_RATE, $urandom_range(1, 20000));
      write_reg(REG_LEAK_COND, $urandom_range(0, 4000000));
      write_reg(REG_REST_POTENTIAL, -$urandom_range(0, 6000000));
      write_reg(REG_THRESHOLD, -$urandom_range(0, 4000000));
      write_reg(REG_SLOPE_FACTOR, $urandom);
      write_reg(REG_ADAPT_COUPLING, $urandom);
      write_reg(REG_ADAPT_INCREMENT, $urandom);
      write_reg(REG_SPIKE_POTENTIAL, $urandom_range(0, 3000000));
      random_phase(150);
    end

    wait_drained();
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
